// ===== rtl/core/button_multi_click_lock_controller_defines.svh =====
// Assertion macros used by the button click lock controller top level.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef BUTTON_MULTI_CLICK_LOCK_CONTROLLER_DEFINES_SVH
`define BUTTON_MULTI_CLICK_LOCK_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BMCLC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMCLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bmclc_pkg.sv =====
// Types and constants for the button click lock controller.
// No dependencies; used by bmclc_decide and the top level.
package bmclc_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_DATA_W   = 40;
    localparam int unsigned M_DATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_TMO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEMO_MODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSIT_MODE = 3'd4;

    localparam logic [15:0] DEBOUNCE_RST     = 16'd50;
    localparam logic [15:0] DOUBLE_WIN_RST   = 16'd600;
    localparam logic [15:0] BURST_TMO_RST    = 16'd1000;
    localparam logic [2:0]  DEMO_MODE_RST    = 3'd0;
    localparam logic [2:0]  TRANSIT_MODE_RST = 3'd1;

    localparam logic [1:0] CLICKS_MAX = 2'd3;

    typedef enum logic [2:0] {
        ACT_NONE        = 3'd0,
        ACT_MUTE        = 3'd1,
        ACT_DEMO_ON     = 3'd2,
        ACT_DEMO_OFF    = 3'd3,
        ACT_TRANSIT_ON  = 3'd4,
        ACT_TRANSIT_OFF = 3'd5,
        ACT_REJECT      = 3'd6
    } action_t;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] double_window_ms;
        logic [15:0] burst_timeout_ms;
        logic [2:0]  demo_mode_code;
        logic [2:0]  transit_mode_code;
    } cfg_t;

    typedef struct packed {
        logic        stable_level;
        logic [31:0] last_change_time;
        logic [1:0]  click_count;
        logic [31:0] first_click_time;
        logic        demo_lock;
        logic        transit_lock;
        logic [2:0]  mode_before_demo;
        logic [2:0]  mode_before_transit;
    } state_t;

    // First field in the highest bits.
    typedef struct packed {
        logic [2:0]  current_mode;
        logic [31:0] now_ms;
        logic        button_level;
    } item_t;

    typedef struct packed {
        logic        transit_locked_now;
        logic        demo_locked_now;
        logic [2:0]  new_mode;
        action_t     action;
    } result_t;

endpackage

// ===== rtl/core/button_multi_click_lock_controller.sv =====
// Top level of the button click lock controller: stream ports, registers, config.
// Depends on bmclc_pkg, bmclc_decide and button_multi_click_lock_controller_defines.svh.
//
// Each input transaction carries one sample of an active-low button pin, a wrapping
// millisecond timestamp and the mode in force; each one yields exactly one output
// transaction with the action taken (none, mute toggle, demo or transit lock on/off,
// or rejected), the mode to apply and both lock flags after the step. A level change
// counts only when more than debounce_ms has passed since the last accepted change;
// three presses inside burst_timeout_ms toggle mute, two presses whose burst age
// lands between double_window_ms and burst_timeout_ms toggle the demo lock, and a
// single press toggles the transit lock once its burst has aged past the timeout.
// Throughput is one transaction per clock while results are taken: the sample sits
// in an input register, one pass of compare and subtract logic updates the state and
// fills the result register, which holds the result until it is taken. A full result
// register that is not being taken holds the sample in the input register, and the
// input side then stalls until the result drains. Write the config registers only
// while no transaction is in flight.
module button_multi_click_lock_controller (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // {current_mode[2:0], now_ms[31:0], button_level}, zero-padded to 40 bits
    input  logic [bmclc_pkg::S_DATA_W-1:0]        s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // {transit_locked_now, demo_locked_now, new_mode[2:0], action[2:0]}
    output logic [bmclc_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_we,
    input  logic [bmclc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bmclc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import bmclc_pkg::*;

    `include "button_multi_click_lock_controller_defines.svh"

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t out_res_reg;
    result_t res_next;
    logic    out_valid_reg;

    logic    s_fire;
    logic    proc_fire;

    // Process the held sample when the result register is free or draining.
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;

    bmclc_decide u_decide (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (in_item_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // Config registers: out-of-range indexes drop the write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms       <= DEBOUNCE_RST;
            cfg_reg.double_window_ms  <= DOUBLE_WIN_RST;
            cfg_reg.burst_timeout_ms  <= BURST_TMO_RST;
            cfg_reg.demo_mode_code    <= DEMO_MODE_RST;
            cfg_reg.transit_mode_code <= TRANSIT_MODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:     cfg_reg.debounce_ms       <= cfg_wdata;
                REG_DOUBLE_WIN:   cfg_reg.double_window_ms  <= cfg_wdata;
                REG_BURST_TMO:    cfg_reg.burst_timeout_ms  <= cfg_wdata;
                REG_DEMO_MODE:    cfg_reg.demo_mode_code    <= cfg_wdata[2:0];
                REG_TRANSIT_MODE: cfg_reg.transit_mode_code <= cfg_wdata[2:0];
                default:          ;
            endcase
        end
    end

    // Input stage: hold the sample until it is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg <= s_tdata[$bits(item_t)-1:0];
        end
    end

    // Controller state advances once per processed sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.stable_level        <= 1'b1;
            state_reg.last_change_time    <= '0;
            state_reg.click_count         <= '0;
            state_reg.first_click_time    <= '0;
            state_reg.demo_lock           <= 1'b0;
            state_reg.transit_lock        <= 1'b0;
            state_reg.mode_before_demo    <= '0;
            state_reg.mode_before_transit <= '0;
        end
        else if (proc_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register: fill on processing, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            out_res_reg <= res_next;
        end
    end

    `BMCLC_ASSERT_NOW(a_locks_exclusive, 1'b1,
        !(state_reg.demo_lock && state_reg.transit_lock),
        "demo and transit locks held together")
    `BMCLC_ASSERT_NOW(a_mode_zero_without_lock_action,
        out_valid_reg && (out_res_reg.action != ACT_DEMO_ON)
            && (out_res_reg.action != ACT_DEMO_OFF)
            && (out_res_reg.action != ACT_TRANSIT_ON)
            && (out_res_reg.action != ACT_TRANSIT_OFF),
        out_res_reg.new_mode == 3'd0,
        "new_mode set on a non-lock action")
    `BMCLC_ASSERT_NEXT(a_proc_fills_result, proc_fire,
        out_valid_reg && (out_res_reg.demo_locked_now == state_reg.demo_lock)
            && (out_res_reg.transit_locked_now == state_reg.transit_lock),
        "result register out of step with lock state")
    `BMCLC_ASSERT_NOW(a_empty_input_ready, !in_valid_reg, s_tready,
        "input stage empty but not ready")

endmodule

// ===== rtl/core/bmclc_decide.sv =====
// Per-sample debounce, click counting and burst decision logic.
// Depends on bmclc_pkg; purely combinational.
module bmclc_decide (
    input  bmclc_pkg::cfg_t    cfg,
    input  bmclc_pkg::state_t  cur,
    input  bmclc_pkg::item_t   item,
    output bmclc_pkg::state_t  nxt,
    output bmclc_pkg::result_t res
);
    import bmclc_pkg::*;

    logic [31:0] since_change;
    logic [31:0] elapsed;
    logic        past_timeout;
    logic        in_window;

    assign since_change = item.now_ms - cur.last_change_time;

    always_comb
    begin
        nxt          = cur;
        res          = '0;
        res.action   = ACT_NONE;

        // Debounced edge: take the new level, count presses.
        if ((item.button_level != cur.stable_level)
            && (since_change > {16'd0, cfg.debounce_ms}))
        begin
            nxt.last_change_time = item.now_ms;
            nxt.stable_level     = item.button_level;
            if (!item.button_level)
            begin
                if (cur.click_count != CLICKS_MAX)
                begin
                    nxt.click_count = cur.click_count + 2'd1;
                end
                if (cur.click_count == 2'd0)
                begin
                    nxt.first_click_time = item.now_ms;
                end
            end
        end

        elapsed      = item.now_ms - nxt.first_click_time;
        past_timeout = (elapsed >= {16'd0, cfg.burst_timeout_ms});
        in_window    = (elapsed >= {16'd0, cfg.double_window_ms}) && !past_timeout;

        // Judge the burst: triple, double, single, then expiry.
        if (nxt.click_count != 2'd0)
        begin
            if ((nxt.click_count == CLICKS_MAX) && !past_timeout)
            begin
                res.action      = ACT_MUTE;
                nxt.click_count = 2'd0;
            end
            else if ((nxt.click_count == 2'd2) && in_window)
            begin
                if (cur.transit_lock && !cur.demo_lock)
                begin
                    res.action = ACT_REJECT;
                end
                else if (cur.demo_lock)
                begin
                    res.new_mode  = cur.mode_before_demo;
                    nxt.demo_lock = 1'b0;
                    res.action    = ACT_DEMO_OFF;
                end
                else
                begin
                    nxt.mode_before_demo = item.current_mode;
                    nxt.demo_lock        = 1'b1;
                    res.new_mode         = cfg.demo_mode_code;
                    res.action           = ACT_DEMO_ON;
                end
                nxt.click_count = 2'd0;
            end
            else if ((nxt.click_count == 2'd1) && past_timeout)
            begin
                if (cur.demo_lock && !cur.transit_lock)
                begin
                    res.action = ACT_REJECT;
                end
                else if (cur.transit_lock)
                begin
                    res.new_mode     = cur.mode_before_transit;
                    nxt.transit_lock = 1'b0;
                    res.action       = ACT_TRANSIT_OFF;
                end
                else
                begin
                    nxt.mode_before_transit = item.current_mode;
                    nxt.transit_lock        = 1'b1;
                    res.new_mode            = cfg.transit_mode_code;
                    res.action              = ACT_TRANSIT_ON;
                end
                nxt.click_count = 2'd0;
            end
            else if (past_timeout)
            begin
                nxt.click_count = 2'd0;
            end
        end

        res.demo_locked_now    = nxt.demo_lock;
        res.transit_locked_now = nxt.transit_lock;
    end

endmodule

// ===== tb/tb_button_multi_click_lock_controller.sv =====
// Self-checking testbench for the button multi-click lock controller stream block.
// Depends on bmclc_pkg and button_multi_click_lock_controller; predicts every result
// in-line from a mirror of the lock state and the config registers.
module tb_button_multi_click_lock_controller;

    timeunit 1ns;
    timeprecision 1ps;

    import bmclc_pkg::*;

    localparam int unsigned HOLD_CYCLES = 300;
    localparam time         RUN_LIMIT   = 200_000ns;

    // Block ports; every input starts at a known value.
    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic [S_DATA_W-1:0]     s_tdata   = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [M_DATA_W-1:0]     m_tdata;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    // Stimulus side: samples waiting to be offered, and the running timestamp.
    item_t       sample_q[$];
    logic [31:0] now_cursor = '0;

    // Handshake bookkeeping shared between driver, receiver and monitor.
    int unsigned stall_pct     = 0;
    int unsigned taken_cnt     = 0;   // bumped by the monitor on each input transaction
    int unsigned seen_cnt      = 0;   // driver's copy of taken_cnt
    int unsigned hold_requests = 0;
    int unsigned holds_done    = 0;
    int unsigned hold_left     = 0;
    int unsigned fail_count    = 0;

    // Expected results, oldest first.
    result_t expected_q[$];

    // Mirror of the block's config and click/lock state.
    cfg_t        cfg_mirror = '{debounce_ms: DEBOUNCE_RST, double_window_ms: DOUBLE_WIN_RST,
                                burst_timeout_ms: BURST_TMO_RST,
                                demo_mode_code: DEMO_MODE_RST,
                                transit_mode_code: TRANSIT_MODE_RST};
    logic        lvl_stable         = 1'b1;
    logic [31:0] t_last_change      = '0;
    logic [1:0]  clicks             = '0;
    logic [31:0] t_first_click      = '0;
    logic        demo_held          = 1'b0;
    logic        transit_held       = 1'b0;
    logic [2:0]  saved_mode_demo    = '0;
    logic [2:0]  saved_mode_transit = '0;

    button_multi_click_lock_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Mirror a register write; unknown indexes leave everything alone.
    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_DEBOUNCE:     cfg_mirror.debounce_ms       = val;
            REG_DOUBLE_WIN:   cfg_mirror.double_window_ms  = val;
            REG_BURST_TMO:    cfg_mirror.burst_timeout_ms  = val;
            REG_DEMO_MODE:    cfg_mirror.demo_mode_code    = val[2:0];
            REG_TRANSIT_MODE: cfg_mirror.transit_mode_code = val[2:0];
            default: ;
        endcase
    endfunction

    // Advance the click/lock mirror by one button sample and return the result it yields.
    function automatic result_t click_decide(item_t smp);
        result_t     r;
        logic [31:0] age;
        logic [31:0] tmo;
        logic [31:0] win;
        r.action             = ACT_NONE;
        r.new_mode           = '0;
        tmo                  = 32'(cfg_mirror.burst_timeout_ms);
        win                  = 32'(cfg_mirror.double_window_ms);

        // Debounce: take a level change only once strictly more than debounce_ms has
        // gone by since the last one, with the difference wrapping at 32 bits.
        if (smp.button_level != lvl_stable &&
            (smp.now_ms - t_last_change) > 32'(cfg_mirror.debounce_ms))
        begin
            t_last_change = smp.now_ms;
            lvl_stable    = smp.button_level;
            if (!smp.button_level)
            begin
                if (clicks != CLICKS_MAX)
                    clicks = clicks + 2'd1;
                if (clicks == 2'd1)
                    t_first_click = smp.now_ms;
            end
        end

        // Judge the burst: mute first, then demo (double), then transit (single).
        if (clicks != 2'd0)
        begin
            age = smp.now_ms - t_first_click;
            if (clicks == CLICKS_MAX && age < tmo)
            begin
                r.action = ACT_MUTE;
                clicks   = '0;
            end
            else if (clicks == 2'd2 && age >= win && age < tmo)
            begin
                if (transit_held && !demo_held)
                    r.action = ACT_REJECT;
                else if (demo_held)
                begin
                    r.new_mode = saved_mode_demo;
                    demo_held  = 1'b0;
                    r.action   = ACT_DEMO_OFF;
                end
                else
                begin
                    saved_mode_demo = smp.current_mode;
                    demo_held       = 1'b1;
                    r.new_mode      = cfg_mirror.demo_mode_code;
                    r.action        = ACT_DEMO_ON;
                end
                clicks = '0;
            end
            else if (clicks == 2'd1 && age >= tmo)
            begin
                if (demo_held && !transit_held)
                    r.action = ACT_REJECT;
                else if (transit_held)
                begin
                    r.new_mode   = saved_mode_transit;
                    transit_held = 1'b0;
                    r.action     = ACT_TRANSIT_OFF;
                end
                else
                begin
                    saved_mode_transit = smp.current_mode;
                    transit_held       = 1'b1;
                    r.new_mode         = cfg_mirror.transit_mode_code;
                    r.action           = ACT_TRANSIT_ON;
                end
                clicks = '0;
            end
            else if (age >= tmo)
                clicks = '0;    // stale burst: drop it
        end

        r.demo_locked_now    = demo_held;
        r.transit_locked_now = transit_held;
        return r;
    endfunction

    function automatic void check_field(string label, int unsigned want, int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            // Check the output transaction against the oldest expectation.
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata);
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual 0x%02h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("action", want.action, got.action);
                    check_field("new_mode", want.new_mode, got.new_mode);
                    check_field("demo_locked_now", want.demo_locked_now, got.demo_locked_now);
                    check_field("transit_locked_now", want.transit_locked_now,
                                got.transit_locked_now);
                end
            end
            // Predict from each accepted input transaction.
            if (s_tvalid && s_tready)
            begin
                expected_q.push_back(click_decide(item_t'(s_tdata[35:0])));
                taken_cnt++;
            end
            if (cfg_we)
                apply_reg(cfg_index, cfg_wdata);
        end
    end

    // ------------------------------------------------------------------
    // Driver: offer the next pending sample at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic  busy;
        item_t nxt;
        if (rst_n)
        begin
            // Hold the current offer until the monitor has seen it go through.
            busy     = s_tvalid && (taken_cnt == seen_cnt);
            seen_cnt = taken_cnt;
            if (!busy)
            begin
                if (sample_q.size() != 0 && $urandom_range(0, 99) >= stall_pct)
                begin
                    nxt = sample_q.pop_front();
                    s_tdata  <= {4'b0, nxt};
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request so the
    // block fills up and stalls its input.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (holds_done != hold_requests)
        begin
            holds_done <= holds_done + 1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [2:0] any_mode();
        return 3'($urandom_range(0, 7));
    endfunction

    // Queue one sample at an absolute timestamp; the cursor follows it.
    task automatic queue_sample(input logic lvl, input logic [31:0] stamp, input logic [2:0] mode);
        item_t it;
        now_cursor      = stamp;
        it.button_level = lvl;
        it.now_ms       = stamp;
        it.current_mode = mode;
        sample_q.push_back(it);
    endtask

    // Well-formed burst: 1 to 4 clean clicks, each edge more than the debounce time after the last,
    // an occasional bounce, then one probe aged up to the timeout, inside the window or past it.
    task automatic queue_burst();
        int unsigned deb;
        int unsigned win;
        int unsigned tmo;
        int unsigned span;
        int unsigned clicks_wanted;
        int unsigned offset;
        logic [31:0] start;
        logic [31:0] age;
        deb           = cfg_mirror.debounce_ms;
        win           = cfg_mirror.double_window_ms;
        tmo           = cfg_mirror.burst_timeout_ms;
        span          = tmo / 6 + 4;
        clicks_wanted = $urandom_range(1, 4);
        start         = now_cursor;
        for (int k = 0; k < clicks_wanted; k++)
        begin
            queue_sample(1'b0, now_cursor + deb + 1 + $urandom_range(0, span), any_mode());
            if (k == 0)
                start = now_cursor;
            if (deb > 0 && $urandom_range(0, 9) == 0)
                queue_sample(1'b1, now_cursor + $urandom_range(1, deb), any_mode());
            queue_sample(1'b1, now_cursor + deb + 1 + $urandom_range(0, span), any_mode());
        end
        case ($urandom_range(0, 2))
            0:       offset = $urandom_range(0, tmo);
            1:       offset = win + $urandom_range(0, (tmo > win) ? tmo - win - 1 : 8);
            default: offset = tmo + $urandom_range(0, 64);
        endcase
        age = now_cursor - start;
        queue_sample(1'b1, (offset > age) ? start + offset : now_cursor + 1, any_mode());
    endtask

    // Noise: random level, either close to the debounce time or at a random timestamp.
    task automatic queue_noise();
        int unsigned deb;
        deb = cfg_mirror.debounce_ms;
        if ($urandom_range(0, 3) == 0)
            queue_sample(1'($urandom_range(0, 1)), $urandom, any_mode());
        else
            queue_sample(1'($urandom_range(0, 1)),
                         now_cursor + $urandom_range(0, 2 * deb + 16), any_mode());
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned target;
        target = sample_q.size() + count;
        while (sample_q.size() < target)
        begin
            if ($urandom_range(0, 99) < 80)
                queue_burst();
            else
                queue_noise();
        end
    endtask

    // Wait until every sample is through and every result is back, then let the
    // pipeline settle before anything else happens.
    task automatic drain();
        do
        begin
            @(posedge clk);
            #0.5;
        end
        while (sample_q.size() != 0 || s_tvalid || expected_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] deb, input logic [15:0] win,
                              input logic [15:0] tmo, input logic [15:0] demo_code,
                              input logic [15:0] transit_code);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_DOUBLE_WIN, win);
        write_reg(REG_BURST_TMO, tmo);
        write_reg(REG_DEMO_MODE, demo_code);
        write_reg(REG_TRANSIT_MODE, transit_code);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        stall_pct = 9;

        // Directed walk at reset config (debounce 50, window 600, timeout 1000).
        queue_sample(1'b1, 32'd0, 3'd0);       // idle sample at time zero
        queue_sample(1'b0, 32'd50, 3'd0);      // exactly the debounce time: not taken
        queue_sample(1'b0, 32'd51, 3'd7);      // one past it: first click
        queue_sample(1'b1, 32'd60, 3'd2);      // bounce inside debounce: ignored
        queue_sample(1'b1, 32'd102, 3'd4);
        queue_sample(1'b1, 32'd1051, 3'd5);    // single click aged out: transit on
        queue_sample(1'b0, 32'd1200, 3'd1);
        queue_sample(1'b1, 32'd1300, 3'd6);
        queue_sample(1'b0, 32'd1400, 3'd3);
        queue_sample(1'b1, 32'd1800, 3'd7);    // double while transit held: rejected
        queue_sample(1'b0, 32'd1900, 3'd0);
        queue_sample(1'b1, 32'd2000, 3'd1);
        queue_sample(1'b1, 32'd2900, 3'd2);    // single again: transit off, saved mode back
        queue_sample(1'b0, 32'd3000, 3'd4);
        queue_sample(1'b1, 32'd3100, 3'd5);
        queue_sample(1'b0, 32'd3200, 3'd6);
        queue_sample(1'b1, 32'd3600, 3'd3);    // double at the window edge: demo on
        queue_sample(1'b0, 32'd3700, 3'd7);
        queue_sample(1'b1, 32'd3800, 3'd0);
        queue_sample(1'b1, 32'd4700, 3'd1);    // single while demo held: rejected
        queue_sample(1'b0, 32'd4800, 3'd2);
        queue_sample(1'b1, 32'd4900, 3'd3);
        queue_sample(1'b0, 32'd5000, 3'd4);
        queue_sample(1'b1, 32'd5100, 3'd5);
        queue_sample(1'b0, 32'd5200, 3'd6);    // third press inside timeout: mute
        queue_sample(1'b1, 32'hFFFF_FFFF, 3'd7); // top of the timestamp; later ones wrap
        queue_random(150);
        drain();

        // All-zero timing: a single press toggles transit at once. Run with no idling.
        stall_pct = 0;
        set_config(16'd0, 16'd0, 16'd0, 16'd7, 16'd7);
        queue_random(80);
        drain();

        // All-ones timing: window equals timeout, so no double click is ever decided.
        stall_pct = 9;
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd3, 16'd5);
        queue_random(80);
        drain();

        // Window above timeout.
        set_config(16'd20, 16'd900, 16'd300, 16'd2, 16'd6);
        queue_random(80);
        drain();

        // Tight timing plus writes to unused indexes, which must change nothing.
        set_config(16'd10, 16'd200, 16'd500, 16'd5, 16'd4);
        write_reg(CFG_IDX_W'(5), 16'($urandom));
        write_reg(CFG_IDX_W'(6), 16'($urandom));
        write_reg(CFG_IDX_W'(7), 16'($urandom));
        queue_random(250);
        hold_requests++;                    // long receiver hold-off while samples keep coming
        drain();

        // Back to the reset values.
        set_config(DEBOUNCE_RST, DOUBLE_WIN_RST, BURST_TMO_RST,
                   16'(DEMO_MODE_RST), 16'(TRANSIT_MODE_RST));
        queue_random(100);
        drain();

        if (fail_count == 0)
            $display("tb_button_multi_click_lock_controller passed");
        else
            $display("tb_button_multi_click_lock_controller failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #(RUN_LIMIT);
        $display("tb_button_multi_click_lock_controller failed");
        $finish;
    end

endmodule
